// File: sv/host_rate_average_ban_detector_macros.svh
// Assertion macros shared by the host rate average ban detector.
`ifndef HOST_RATE_AVERAGE_BAN_DETECTOR_MACROS_SVH
`define HOST_RATE_AVERAGE_BAN_DETECTOR_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define HRABD_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define HRABD_ASSERT_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define HRABD_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/hrabd_pkg.sv
// Package with types, constants and codes of the host rate average ban detector.
`timescale 1ns / 1ps

package hrabd_pkg;

   // Item field widths
   localparam int HOST_W    = 8;
   localparam int METRIC_W  = 3;
   localparam int COUNT_W   = 48;
   localparam int LIMIT_W   = 32;
   localparam int METRICS   = 8;
   localparam int HOST_CODES = 2 ** HOST_W;

   // Arithmetic widths
   localparam int RECIP_W   = 32;
   localparam int FACTOR_W  = 16;
   localparam int PROD_W    = 64;
   localparam int LANES     = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LIMIT_SETS  = 4;
   localparam logic [RECIP_W-1:0] RATE_RECIP_RESET = 32'h0001_0000;

   // Parameter defaults
   localparam int HOSTS_DEFAULT      = 256;
   localparam int MBPS_SHIFT_DEFAULT = 17;

   // Depth of the queues between the parts
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RATE_RECIPROCAL   = 3'd0,
      CSR_SMOOTHING_FACTOR  = 3'd1,
      CSR_CHECK_ENABLE_MASK = 3'd2,
      CSR_LIMITS_TOTAL      = 3'd3,
      CSR_LIMITS_TCP        = 3'd4,
      CSR_LIMITS_UDP        = 3'd5,
      CSR_LIMITS_ICMP       = 3'd6
   } csr_reg_type;

   // Back sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RATE,
      ST_DIFF,
      ST_MUL,
      ST_UPDATE,
      ST_FINISH
   } back_state_type;

   // Classified item handed from the front to the back
   typedef struct packed {
      logic [HOST_W-1:0]   host;
      logic [METRIC_W-1:0] metric;
      logic                check_en;
      logic                is_bytes;
      logic [LIMIT_W-1:0]  limit;
      logic [COUNT_W-1:0]  in_count;
      logic [COUNT_W-1:0]  out_count;
   } task_type;

   // Result item
   typedef struct packed {
      logic [HOST_W-1:0]   host_echo;
      logic [METRIC_W-1:0] metric_echo;
      logic [COUNT_W-1:0]  avg_in_rate;
      logic [COUNT_W-1:0]  avg_out_rate;
      logic                metric_exceeded;
      logic                host_ban;
   } rsp_type;

   // Control from the back to the queues
   typedef struct packed {
      logic task_pop;
      logic out_push;
      logic clearing;
   } back_ctrl_type;

endpackage

// File: sv/hrabd_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module hrabd_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 2,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/hrabd_fifo.sv
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps

module hrabd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: sv/hrabd_front.sv
// Front part: accepts items, maps the host to its slot and selects the limit.
`timescale 1ns / 1ps

module hrabd_front import hrabd_pkg::*; #(
   parameter int  HOSTS  = HOSTS_DEFAULT,
   localparam int SLOT_W = (HOSTS > 1) ? $clog2(HOSTS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              hold,
   input  logic                              push,
   output logic                              full,
   input  logic [HOST_W-1:0]                 host,
   input  logic [METRIC_W-1:0]               metric,
   input  logic [COUNT_W-1:0]                in_count,
   input  logic [COUNT_W-1:0]                out_count,
   input  logic [METRICS-1:0]                check_enable_mask,
   input  logic [LIMIT_SETS-1:0][CSR_DATA_W-1:0] limits,
   input  logic                              q_full,
   output logic                              q_push,
   output task_type                          q_item,
   output logic [SLOT_W-1:0]                 q_slot
);

   logic [SLOT_W-1:0] slot_table [HOST_CODES];
   logic              valid_ff, valid_in;
   task_type          item_ff, item_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              accept;
   logic [CSR_DATA_W-1:0] limit_word;

   // Host to slot table, host modulo HOSTS
   for (genvar g = 0; g < HOST_CODES; g++) begin : g_slot
      assign slot_table[g] = SLOT_W'(g % HOSTS);
   end

   assign full   = hold || (valid_ff && q_full);
   assign accept = push && !full;
   assign q_push = valid_ff && !q_full;
   assign q_item = item_ff;
   assign q_slot = slot_ff;

   // Classify the incoming item
   always_comb begin
      limit_word       = limits[metric[METRIC_W-1:1]];
      item_in          = item_ff;
      slot_in          = slot_ff;
      if (accept) begin
         item_in.host      = host;
         item_in.metric    = metric;
         item_in.check_en  = check_enable_mask[metric];
         item_in.is_bytes  = metric[0];
         item_in.limit     = metric[0] ? limit_word[CSR_DATA_W-1:LIMIT_W]
                                       : limit_word[LIMIT_W-1:0];
         item_in.in_count  = in_count;
         item_in.out_count = out_count;
         slot_in           = slot_table[host];
      end
      valid_in = accept || (valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the staged item
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      slot_ff <= slot_in;
   end

endmodule

// File: sv/hrabd_back.sv
// Back part: sequencer that scales, smooths, checks and stores one item at a time.
`timescale 1ns / 1ps

module hrabd_back import hrabd_pkg::*; #(
   parameter int  HOSTS      = HOSTS_DEFAULT,
   parameter int  MBPS_SHIFT = MBPS_SHIFT_DEFAULT,
   localparam int SLOT_W     = (HOSTS > 1) ? $clog2(HOSTS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [RECIP_W-1:0]  rate_reciprocal,
   input  logic [FACTOR_W-1:0] smoothing_factor,
   input  logic                task_empty,
   input  task_type            task_item,
   input  logic [SLOT_W-1:0]   task_slot,
   input  logic                out_full,
   output rsp_type             out_item,
   output back_ctrl_type       ctrl
);

   localparam int AVG_DEPTH = HOSTS * METRICS;
   localparam int AVG_AW    = $clog2(AVG_DEPTH);
   localparam int AVG_DW    = LANES * COUNT_W;
   localparam int HALF_W    = RECIP_W / 2;

   back_state_type state_ff, state_in;
   logic [AVG_AW-1:0] clr_ff, clr_in;
   logic              clr_last;
   logic              start;

   task_type          item_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [PROD_W-1:0]  p_hi_ff [LANES];
   logic [PROD_W-1:0]  p_lo_ff [LANES];
   logic [COUNT_W-1:0] rate_ff [LANES];
   logic               ge_ff   [LANES];
   logic [COUNT_W-1:0] diff_ff [LANES];
   logic [PROD_W-1:0]  prod_ff [LANES];
   logic [COUNT_W-1:0] avg_ff  [LANES];

   logic [COUNT_W-1:0] lane_count [LANES];
   logic [COUNT_W-1:0] avg_old    [LANES];
   logic               over       [LANES];

   logic              avg_we, avg_re;
   logic [AVG_AW-1:0] avg_wr_addr, avg_rd_addr;
   logic [AVG_DW-1:0] avg_wr_data, avg_rd_data;
   logic              ex_we;
   logic [SLOT_W-1:0] ex_wr_addr;
   logic [METRICS-1:0] ex_wr_data, ex_rd_data, ex_new;
   logic              hit;

   // Scale product pair to a rate, saturating at the count width
   function automatic logic [COUNT_W-1:0] scale_sat(input logic [PROD_W-1:0] hi,
                                                    input logic [PROD_W-1:0] lo);
      logic [COUNT_W:0] sum;
      sum = {1'b0, hi[COUNT_W-1:0]} + {1'b0, lo[PROD_W-1:FACTOR_W]};
      if ((hi[PROD_W-1:COUNT_W] != '0) || sum[COUNT_W]) begin
         return '1;
      end
      return sum[COUNT_W-1:0];
   endfunction

   assign clr_last      = (clr_ff == AVG_AW'(AVG_DEPTH - 1));
   assign start         = !task_empty && !out_full;
   assign lane_count[0] = task_item.in_count;
   assign lane_count[1] = task_item.out_count;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = ST_RATE;
         ST_RATE:   state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Control outputs
   always_comb begin
      ctrl.task_pop = 1'b0;
      ctrl.out_push = 1'b0;
      ctrl.clearing = 1'b0;
      avg_we        = 1'b0;
      ex_we         = 1'b0;
      clr_in        = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.clearing = 1'b1;
            avg_we        = 1'b1;
            ex_we         = 1'b1;
            clr_in        = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            ctrl.task_pop = start;
         end
         ST_FINISH: begin
            ctrl.out_push = 1'b1;
            avg_we        = 1'b1;
            ex_we         = 1'b1;
         end
         default: begin
         end
      endcase
      avg_re = ctrl.task_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Datapath: one step of the item per state
   always_ff @(posedge clock) begin
      if (ctrl.task_pop) begin
         item_ff <= task_item;
         slot_ff <= task_slot;
         for (int l = 0; l < LANES; l++) begin
            p_hi_ff[l] <= {{(PROD_W-COUNT_W){1'b0}}, lane_count[l]} *
                          {{(PROD_W-HALF_W){1'b0}}, rate_reciprocal[RECIP_W-1:HALF_W]};
            p_lo_ff[l] <= {{(PROD_W-COUNT_W){1'b0}}, lane_count[l]} *
                          {{(PROD_W-HALF_W){1'b0}}, rate_reciprocal[HALF_W-1:0]};
         end
      end
      for (int l = 0; l < LANES; l++) begin
         if (state_ff == ST_RATE) begin
            rate_ff[l] <= scale_sat(p_hi_ff[l], p_lo_ff[l]);
         end
         if (state_ff == ST_DIFF) begin
            ge_ff[l]   <= (avg_old[l] >= rate_ff[l]);
            diff_ff[l] <= (avg_old[l] >= rate_ff[l]) ? avg_old[l] - rate_ff[l]
                                                     : rate_ff[l] - avg_old[l];
         end
         if (state_ff == ST_MUL) begin
            prod_ff[l] <= {{(PROD_W-COUNT_W){1'b0}}, diff_ff[l]} *
                          {{(PROD_W-FACTOR_W){1'b0}}, smoothing_factor};
         end
         if (state_ff == ST_UPDATE) begin
            // Round toward minus infinity: floor the step above the rate, ceiling the step taken below it
            avg_ff[l] <= ge_ff[l]
               ? rate_ff[l] + prod_ff[l][PROD_W-1:FACTOR_W]
               : rate_ff[l] - COUNT_W'((prod_ff[l] + PROD_W'({FACTOR_W{1'b1}}))
                                       >> FACTOR_W);
         end
      end
   end

   // Threshold check and exceed bit update
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         avg_old[l] = avg_rd_data[l*COUNT_W +: COUNT_W];
         if (item_ff.is_bytes) begin
            over[l] = (avg_ff[l] >> MBPS_SHIFT) > COUNT_W'(item_ff.limit);
         end else begin
            over[l] = avg_ff[l] > COUNT_W'(item_ff.limit);
         end
      end
      hit    = item_ff.check_en && (over[0] || over[1]);
      ex_new = hit ? (ex_rd_data | (METRICS'(1) << item_ff.metric))
                   : (ex_rd_data & ~(METRICS'(1) << item_ff.metric));
   end

   // Store addressing: clearing pass or item slot
   always_comb begin
      avg_rd_addr = AVG_AW'({task_slot, task_item.metric});
      if (ctrl.clearing) begin
         avg_wr_addr = clr_ff;
         avg_wr_data = '0;
         ex_wr_addr  = SLOT_W'(clr_ff >> METRIC_W);
         ex_wr_data  = '0;
      end else begin
         avg_wr_addr = AVG_AW'({slot_ff, item_ff.metric});
         avg_wr_data = {avg_ff[1], avg_ff[0]};
         ex_wr_addr  = slot_ff;
         ex_wr_data  = ex_new;
      end
   end

   hrabd_ram #(
      .WIDTH (AVG_DW),
      .DEPTH (AVG_DEPTH)
   ) u_avg_ram (
      .clock   (clock),
      .wr_en   (avg_we),
      .wr_addr (avg_wr_addr),
      .wr_data (avg_wr_data),
      .rd_en   (avg_re),
      .rd_addr (avg_rd_addr),
      .rd_data (avg_rd_data)
   );

   hrabd_ram #(
      .WIDTH (METRICS),
      .DEPTH (HOSTS)
   ) u_exceed_ram (
      .clock   (clock),
      .wr_en   (ex_we),
      .wr_addr (ex_wr_addr),
      .wr_data (ex_wr_data),
      .rd_en   (avg_re),
      .rd_addr (task_slot),
      .rd_data (ex_rd_data)
   );

   // Result item
   always_comb begin
      out_item.host_echo       = item_ff.host;
      out_item.metric_echo     = item_ff.metric;
      out_item.avg_in_rate     = avg_ff[0];
      out_item.avg_out_rate    = avg_ff[1];
      out_item.metric_exceeded = hit;
      out_item.host_ban        = |ex_new;
   end

endmodule

// File: sv/host_rate_average_ban_detector.sv
// Top level of the host rate average ban detector.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ----------------------------
//   input     req_host req_metric req_*_count         push && !full
//   result    rsp_host_echo ... rsp_host_ban          pop && !empty
//   config    csr_index csr_wdata                     csr_write_en
//
// The back sequencer takes an item through read, scale, rate, difference,
// smoothing multiply, update, check and write back, one item at a time.
// After reset a clearing pass over all HOSTS*8 average entries zeroes the average
// and exceed stores; full stays high meanwhile, configuration writes are taken.
// Input and result queues of two items each let either side stall on its own.
`timescale 1ns / 1ps
`include "host_rate_average_ban_detector_macros.svh"

module host_rate_average_ban_detector import hrabd_pkg::*; #(
   parameter int HOSTS      = HOSTS_DEFAULT,
   parameter int MBPS_SHIFT = MBPS_SHIFT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [HOST_W-1:0]      req_host,
   input  logic [METRIC_W-1:0]    req_metric,
   input  logic [COUNT_W-1:0]     req_in_count,
   input  logic [COUNT_W-1:0]     req_out_count,
   output logic                   empty,
   input  logic                   pop,
   output logic [HOST_W-1:0]      rsp_host_echo,
   output logic [METRIC_W-1:0]    rsp_metric_echo,
   output logic [COUNT_W-1:0]     rsp_avg_in_rate,
   output logic [COUNT_W-1:0]     rsp_avg_out_rate,
   output logic                   rsp_metric_exceeded,
   output logic                   rsp_host_ban,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SLOT_W = (HOSTS > 1) ? $clog2(HOSTS) : 1;
   localparam int TASK_W = SLOT_W + $bits(task_type);
   localparam int RSP_W  = $bits(rsp_type);

   logic [RECIP_W-1:0]  rate_recip_ff, rate_recip_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [METRICS-1:0]  enable_ff, enable_in;
   logic [LIMIT_SETS-1:0][CSR_DATA_W-1:0] limits_ff, limits_in;

   logic              front_push, task_full, task_empty;
   task_type          front_item, task_item;
   logic [SLOT_W-1:0] front_slot, task_slot;
   logic [TASK_W-1:0] task_dout;
   logic              out_full;
   rsp_type           back_item, out_item;
   logic [RSP_W-1:0]  out_dout;
   back_ctrl_type     back_ctrl;

   // Configuration register writes
   always_comb begin
      rate_recip_in = rate_recip_ff;
      factor_in     = factor_ff;
      enable_in     = enable_ff;
      limits_in     = limits_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RATE_RECIPROCAL:   rate_recip_in = csr_wdata[RECIP_W-1:0];
            CSR_SMOOTHING_FACTOR:  factor_in     = csr_wdata[FACTOR_W-1:0];
            CSR_CHECK_ENABLE_MASK: enable_in     = csr_wdata[METRICS-1:0];
            CSR_LIMITS_TOTAL:      limits_in[0]  = csr_wdata;
            CSR_LIMITS_TCP:        limits_in[1]  = csr_wdata;
            CSR_LIMITS_UDP:        limits_in[2]  = csr_wdata;
            CSR_LIMITS_ICMP:       limits_in[3]  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_recip_ff <= RATE_RECIP_RESET;
         factor_ff     <= '0;
         enable_ff     <= '0;
         limits_ff     <= '0;
      end else begin
         rate_recip_ff <= rate_recip_in;
         factor_ff     <= factor_in;
         enable_ff     <= enable_in;
         limits_ff     <= limits_in;
      end
   end

   hrabd_front #(
      .HOSTS (HOSTS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .hold              (back_ctrl.clearing),
      .push              (push),
      .full              (full),
      .host              (req_host),
      .metric            (req_metric),
      .in_count          (req_in_count),
      .out_count         (req_out_count),
      .check_enable_mask (enable_ff),
      .limits            (limits_ff),
      .q_full            (task_full),
      .q_push            (front_push),
      .q_item            (front_item),
      .q_slot            (front_slot)
   );

   // Queue between front and back
   hrabd_fifo #(
      .WIDTH (TASK_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_task_fifo (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .din   ({front_slot, front_item}),
      .full  (task_full),
      .pop   (back_ctrl.task_pop),
      .dout  (task_dout),
      .empty (task_empty)
   );

   assign task_slot = task_dout[TASK_W-1:$bits(task_type)];
   assign task_item = task_type'(task_dout[$bits(task_type)-1:0]);

   hrabd_back #(
      .HOSTS      (HOSTS),
      .MBPS_SHIFT (MBPS_SHIFT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .rate_reciprocal  (rate_recip_ff),
      .smoothing_factor (factor_ff),
      .task_empty       (task_empty),
      .task_item        (task_item),
      .task_slot        (task_slot),
      .out_full         (out_full),
      .out_item         (back_item),
      .ctrl             (back_ctrl)
   );

   // Result queue
   hrabd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (back_ctrl.out_push),
      .din   (back_item),
      .full  (out_full),
      .pop   (pop),
      .dout  (out_dout),
      .empty (empty)
   );

   assign out_item            = rsp_type'(out_dout);
   assign rsp_host_echo       = out_item.host_echo;
   assign rsp_metric_echo     = out_item.metric_echo;
   assign rsp_avg_in_rate     = out_item.avg_in_rate;
   assign rsp_avg_out_rate    = out_item.avg_out_rate;
   assign rsp_metric_exceeded = out_item.metric_exceeded;
   assign rsp_host_ban        = out_item.host_ban;

   // Checks
   `HRABD_ASSERT_IMPLY(a_no_push_when_full, back_ctrl.out_push, !out_full, "result pushed into full queue")
   `HRABD_ASSERT_IMPLY(a_clear_blocks_input, back_ctrl.clearing, full, "input open during clearing pass")
   `HRABD_ASSERT_NEXT(a_push_shows_result, back_ctrl.out_push, !empty, "pushed result not visible")
   `HRABD_ASSERT_IMPLY(a_pop_has_item, back_ctrl.task_pop, !task_empty, "back took item from empty queue")
   `HRABD_ASSERT_ALWAYS(a_single_activity, !(back_ctrl.task_pop && back_ctrl.out_push), "start and finish overlap")

endmodule
